@@ src/tfc_pkg.sv @@
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types and constants for the telemetry frame checker: frame phases,
// error codes, frame layout and register constants and the result record.
// ----------------------------------------------------------------------------
package tfc_pkg;

    // Frame layout: marker, length, sender id, message id ... check a, check b
    localparam logic [7:0] HEADER_BYTES = 8'd4;
    localparam logic [7:0] TAIL_BYTES   = 8'd2;
    localparam logic [7:0] MIN_FRAME    = HEADER_BYTES + TAIL_BYTES;

    // Byte positions within a frame (marker is position 0)
    localparam logic [7:0] POS_SENDER  = 8'd2;
    localparam logic [7:0] POS_MESSAGE = 8'd3;

    // Register file
    localparam int unsigned PADDR_W      = 3;
    localparam int unsigned PDATA_W      = 32;
    localparam logic        REG_MARKER   = 1'b0;     // register index 0
    localparam logic [7:0]  MARKER_RESET = 8'd153;

    // Receive phase
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY,
        PH_CKB
    } t_phase;

    // Error kind as reported on the result
    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_SHORT,
        ERR_CHECK_A,
        ERR_CHECK_B
    } t_err;

    // One frame result
    typedef struct packed {
        logic       frame_ok;
        t_err       error_kind;
        logic [7:0] frame_length;
        logic [7:0] sender_id;
        logic [7:0] message_id;
    } t_result;

endpackage : tfc_pkg

@@ src/telemetry_frame_checker.sv @@
// ----------------------------------------------------------------------------
// telemetry_frame_checker
// Finds frames in a telemetry byte stream and checks their two 8-bit
// Fletcher-style check bytes, reporting one result per frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Payload
//  input     in         i_in_valid / o_in_stall     i_data_byte
//  result    out        o_out_valid / i_out_stall   o_frame_ok, o_error_kind,
//                                                   o_frame_length, o_sender_id,
//                                                   o_message_id
//  config    in         APB (psel, penable, ...)    start marker at address 0
//
//  One byte per cycle while the input is not stalled: a byte is registered,
//  then the frame logic handles it and loads the result register on the last
//  frame byte. o_out_valid comes from the result register, so the final check
//  byte passes the input and result registers before the result transfers.
//  Synchronous active-low reset puts the receiver in hunt and empties both
//  registers; the start marker returns to 153.
//  A stalled result stops the input only when the next byte would end a frame.
// ----------------------------------------------------------------------------
module telemetry_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_frame_ok,
    output tfc_pkg::t_err                 o_error_kind,
    output logic [7:0]                    o_frame_length,
    output logic [7:0]                    o_sender_id,
    output logic [7:0]                    o_message_id,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tfc_pkg::PADDR_W-1:0]   paddr,
    input  logic [tfc_pkg::PDATA_W-1:0]   pwdata,
    output logic [tfc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import tfc_pkg::*;

    logic       sel_marker;
    logic [7:0] r_start_marker;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_result;

    logic       cfg_write;
    logic       out_free;
    logic       fsm_hit;
    logic       s1_advance;
    logic       s1_emit;
    logic       in_accept;
    t_result    fsm_result;

    // Register access
    assign pready     = 1'b1;
    assign sel_marker = (paddr[PADDR_W-1] == REG_MARKER);
    assign cfg_write  = psel && penable && pwrite && sel_marker;
    assign prdata     = sel_marker ? {{(PDATA_W-8){1'b0}}, r_start_marker} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= MARKER_RESET;
        end else if (cfg_write) begin
            r_start_marker <= pwdata[7:0];
        end
    end

    // Pipeline control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_advance = r_in_valid && (!fsm_hit || out_free);
    assign s1_emit    = s1_advance && fsm_hit;
    assign o_in_stall = r_in_valid && !s1_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (s1_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
        end
    end

    // Frame receiver
    tfc_frame_fsm u_frame_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_advance),
        .i_byte   (r_in_byte),
        .i_marker (r_start_marker),
        .o_hit    (fsm_hit),
        .o_result (fsm_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            r_result <= fsm_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_ok     = r_result.frame_ok;
    assign o_error_kind   = r_result.error_kind;
    assign o_frame_length = r_result.frame_length;
    assign o_sender_id    = r_result.sender_id;
    assign o_message_id   = r_result.message_id;

`ifndef NO_ASSERTIONS
    // pass flag agrees with the error kind
    a_ok_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_ok == (o_error_kind == ERR_NONE)))
        else $error("frame_ok disagrees with error_kind");

    // short frames carry a short length and no ids
    a_short_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_error_kind == ERR_SHORT)) |->
            ((o_frame_length < MIN_FRAME) && (o_sender_id == 8'd0)
             && (o_message_id == 8'd0)))
        else $error("short-frame result malformed");

    // a checked frame was at least the minimum length
    a_checked_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_error_kind != ERR_SHORT)) |->
            (o_frame_length >= MIN_FRAME))
        else $error("checked frame shorter than minimum");

    // a pending result is never overwritten by a new one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !s1_emit)
        else $error("result register overwritten while stalled");
`endif

endmodule : telemetry_frame_checker

@@ src/tfc_frame_fsm.sv @@
// ----------------------------------------------------------------------------
// tfc_frame_fsm
// Frame receiver: hunts for the start marker, tracks the frame position,
// keeps the two running sums and forms the result on the last frame byte.
// ----------------------------------------------------------------------------
module tfc_frame_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,      // consume i_byte this cycle
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_marker,
    output logic             o_hit,       // i_byte ends a frame
    output tfc_pkg::t_result o_result
);
    import tfc_pkg::*;

    t_phase     r_phase,   n_phase;
    logic [7:0] r_sum_a,   n_sum_a;
    logic [7:0] r_sum_b,   n_sum_b;
    logic [7:0] r_pos,     n_pos;
    logic [7:0] r_len,     n_len;
    logic [7:0] r_sender,  n_sender;
    logic [7:0] r_message, n_message;
    logic [7:0] r_check_a, n_check_a;

    logic [7:0] sum_a_add;
    logic       at_check_a;

    assign sum_a_add  = r_sum_a + i_byte;
    assign at_check_a = (r_pos == 8'(r_len - TAIL_BYTES));

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_pos     = r_pos;
        n_len     = r_len;
        n_sender  = r_sender;
        n_message = r_message;
        n_check_a = r_check_a;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_marker) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_len = i_byte;
                if (i_byte < MIN_FRAME) begin
                    n_phase = PH_HUNT;
                end else begin
                    // sums start over with the length byte
                    n_sum_a = i_byte;
                    n_sum_b = i_byte;
                    n_pos   = POS_SENDER;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (at_check_a) begin
                    n_check_a = i_byte;
                    n_phase   = PH_CKB;
                end else begin
                    if (r_pos == POS_SENDER) begin
                        n_sender = i_byte;
                    end
                    if (r_pos == POS_MESSAGE) begin
                        n_message = i_byte;
                    end
                    n_sum_a = sum_a_add;
                    n_sum_b = r_sum_b + sum_a_add;
                    n_pos   = r_pos + 8'd1;
                end
            end
            PH_CKB: begin
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // Result for the byte at the input
    always_comb begin
        o_hit                 = 1'b0;
        o_result.frame_ok     = 1'b0;
        o_result.error_kind   = ERR_NONE;
        o_result.frame_length = r_len;
        o_result.sender_id    = r_sender;
        o_result.message_id   = r_message;
        unique case (r_phase)
            PH_LEN: begin
                if (i_byte < MIN_FRAME) begin
                    o_hit                 = 1'b1;
                    o_result.error_kind   = ERR_SHORT;
                    o_result.frame_length = i_byte;
                    o_result.sender_id    = 8'd0;
                    o_result.message_id   = 8'd0;
                end
            end
            PH_CKB: begin
                o_hit = 1'b1;
                // check a mismatch wins over check b
                priority if (r_check_a != r_sum_a) begin
                    o_result.error_kind = ERR_CHECK_A;
                end else if (i_byte != r_sum_b) begin
                    o_result.error_kind = ERR_CHECK_B;
                end else begin
                    o_result.frame_ok   = 1'b1;
                end
            end
            default: begin
                o_hit = 1'b0;
            end
        endcase
    end

    // Phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

    // Frame context, always written before it is read
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_sum_a   <= n_sum_a;
            r_sum_b   <= n_sum_b;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_sender  <= n_sender;
            r_message <= n_message;
            r_check_a <= n_check_a;
        end
    end

endmodule : tfc_frame_fsm
